### design/sbrs_pkg.sv
// shared types and constants of the lockstep request scheduler
// no dependencies; imported by every module of the block
package sbrs_pkg;

    localparam int TAG_W       = 16;
    localparam int WORKER_W    = 3;
    localparam int MAX_RESULTS = 16;
    localparam int NCNT_W      = $clog2(MAX_RESULTS + 1);
    localparam int CMDQ_DEPTH  = 4;

    localparam logic [3:0] WAIT_MAX = 4'd15;

    localparam logic [1:0] MODE_GET  = 2'd0;
    localparam logic [1:0] MODE_ADD  = 2'd1;
    localparam logic [1:0] MODE_FIN  = 2'd2;
    localparam logic [1:0] MODE_NONE = 2'd3;

    localparam logic CFG_SYNC = 1'b0;
    localparam logic CFG_ACT  = 1'b1;

    localparam logic KIND_GET = 1'b0;
    localparam logic KIND_ADD = 1'b1;

    localparam logic [2:0] CMD_GET      = 3'd0;
    localparam logic [2:0] CMD_ADD      = 3'd1;
    localparam logic [2:0] CMD_FIN      = 3'd2;
    localparam logic [2:0] CMD_PASS_GET = 3'd3;
    localparam logic [2:0] CMD_PASS_ADD = 3'd4;

    typedef struct packed {
        logic [1:0]          mode;
        logic [WORKER_W-1:0] worker_index;
        logic [TAG_W-1:0]    request_tag;
        logic                has_payload;
    } req_t;

    typedef struct packed {
        logic                status;
        logic                out_kind;
        logic [WORKER_W-1:0] out_worker;
        logic [TAG_W-1:0]    out_tag;
        logic                send_reply;
        logic                last;
    } rsp_t;

    typedef struct packed {
        logic [2:0]          kind;
        logic [WORKER_W-1:0] worker;
        logic [TAG_W-1:0]    tag;
        logic                pay;
    } cmd_t;

    typedef struct packed {
        logic [TAG_W-1:0]    tag;
        logic [WORKER_W-1:0] worker;
        logic                pay;
    } entry_t;

endpackage

### design/sbrs_front.sv
// front end: accepts requests, folds the worker index, classifies them
// and queues commands for the back end; depends on sbrs_pkg
module sbrs_front #(
    parameter int N_WORKERS = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          sync_enable,
    input  logic          req_valid,
    output logic          req_ready,
    input  sbrs_pkg::req_t req,
    output logic          cmd_valid,
    input  logic          cmd_ready,
    output sbrs_pkg::cmd_t cmd
);
    import sbrs_pkg::*;

    localparam int QW  = $clog2(CMDQ_DEPTH);
    localparam int QCW = $clog2(CMDQ_DEPTH + 1);

    cmd_t            q_mem [CMDQ_DEPTH];
    logic [QW-1:0]   wp_reg, wp_next, rp_reg, rp_next;
    logic [QCW-1:0]  cnt_reg, cnt_next;
    logic            keep;
    logic            push, pop;
    logic [WORKER_W-1:0] wm;
    cmd_t            c_new;

    always_comb
    begin
        wm = req.worker_index;
        for (int k = 0; k < 8; k++)
        begin
            if (int'(wm) >= N_WORKERS)
            begin
                wm = wm - WORKER_W'(N_WORKERS);
            end
        end
        keep        = 1'b1;
        c_new.worker = wm;
        c_new.tag    = req.request_tag;
        c_new.pay    = req.has_payload;
        c_new.kind   = CMD_GET;
        unique case (req.mode)
            MODE_GET: c_new.kind = sync_enable ? CMD_GET : CMD_PASS_GET;
            MODE_ADD: c_new.kind = sync_enable ? CMD_ADD : CMD_PASS_ADD;
            MODE_FIN:
            begin
                c_new.kind = CMD_FIN;
                keep       = sync_enable;
            end
            default: keep = 1'b0;
        endcase
    end

    assign req_ready = (cnt_reg != QCW'(CMDQ_DEPTH));
    assign push      = req_valid && req_ready && keep;
    assign cmd_valid = (cnt_reg != '0);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = q_mem[rp_reg];

    always_comb
    begin
        wp_next  = push ? wp_reg + 1'b1 : wp_reg;
        rp_next  = pop ? rp_reg + 1'b1 : rp_reg;
        cnt_next = cnt_reg + QCW'(push) - QCW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wp_reg] <= c_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

### design/sbrs_back.sv
// back end: vector clocks, deferral queues and the sequencer that
// releases, defers and drains requests; depends on sbrs_pkg
module sbrs_back #(
    parameter int N_WORKERS = 8,
    parameter int QUEUE_DEPTH = 8,
    parameter int CLOCK_WIDTH = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic [3:0]     active_workers,
    input  logic           cmd_valid,
    output logic           cmd_ready,
    input  sbrs_pkg::cmd_t cmd,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output sbrs_pkg::rsp_t rsp
);
    import sbrs_pkg::*;

    localparam int WIDX = (N_WORKERS > 1) ? $clog2(N_WORKERS) : 1;
    localparam int AW   = $clog2(N_WORKERS + 1);
    localparam int QW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW  = $clog2(QUEUE_DEPTH + 1);
    localparam int CW   = CLOCK_WIDTH;

    localparam logic [3:0] S_FETCH  = 4'd0;
    localparam logic [3:0] S_AHEAD  = 4'd1;
    localparam logic [3:0] S_UPD    = 4'd2;
    localparam logic [3:0] S_SCAN   = 4'd3;
    localparam logic [3:0] S_DECIDE = 4'd4;
    localparam logic [3:0] S_FIN    = 4'd5;
    localparam logic [3:0] S_DRAIN  = 4'd6;
    localparam logic [3:0] S_POP    = 4'd7;
    localparam logic [3:0] S_END    = 4'd8;

    localparam logic [1:0] CX_REL   = 2'd0;
    localparam logic [1:0] CX_DRAIN = 2'd1;
    localparam logic [1:0] CX_FIN1  = 2'd2;
    localparam logic [1:0] CX_FIN2  = 2'd3;

    function automatic logic [WIDX-1:0] widx(input logic [WORKER_W-1:0] w);
        return WIDX'(w);
    endfunction

    // clock count memories with per-entry valid bits
    logic [CW-1:0]          get_loc_mem [N_WORKERS];
    logic [CW-1:0]          add_loc_mem [N_WORKERS];
    logic [N_WORKERS-1:0]   get_vld_reg, add_vld_reg;
    logic [CW-1:0]          get_rd_reg, add_rd_reg;
    logic                   get_rdv_reg, add_rdv_reg;
    logic [WIDX-1:0]        ra;
    logic                   loc_we;
    logic [CW-1:0]          loc_wdata;

    // deferral queues
    entry_t                 gq_mem [QUEUE_DEPTH];
    entry_t                 aq_mem [QUEUE_DEPTH];
    entry_t                 q_rd_reg;
    logic [QW-1:0]          gq_head_reg, gq_head_next, gq_tail_reg, gq_tail_next;
    logic [QW-1:0]          aq_head_reg, aq_head_next, aq_tail_reg, aq_tail_next;
    logic [QCW-1:0]         gq_cnt_reg, gq_cnt_next, aq_cnt_reg, aq_cnt_next;
    logic                   q_push, q_pop;
    entry_t                 q_wdata;

    logic [N_WORKERS-1:0]   get_done_reg, get_done_next, add_done_reg, add_done_next;
    logic [CW-1:0]          get_glob_reg, get_glob_next, add_glob_reg, add_glob_next;
    logic [3:0]             waited_reg [N_WORKERS];
    logic [3:0]             waited_next [N_WORKERS];

    logic [3:0]             state_reg, state_next;
    logic [WORKER_W-1:0]    w_reg, w_next;
    logic [WORKER_W-1:0]    fw_reg, fw_next;
    logic [TAG_W-1:0]       tag_reg, tag_next;
    logic                   pay_reg, pay_next;
    logic                   is_add_reg, is_add_next;
    logic                   sel_reg, sel_next;
    logic [1:0]             ctx_reg, ctx_next;
    logic                   op_fin_reg, op_fin_next;
    logic                   dkind_reg, dkind_next;
    logic                   fin2_reg, fin2_next;
    logic [NCNT_W-1:0]      n_reg, n_next;
    logic                   pend_vld_reg, pend_vld_next;
    rsp_t                   pend_reg, pend_next;
    logic                   ov_reg, ov_next;
    rsp_t                   out_reg, out_next;
    logic [AW-1:0]          scan_idx_reg, scan_idx_next;
    logic [WIDX-1:0]        scan_ci_reg, scan_ci_next;
    logic                   scan_dv_reg, scan_dv_next;
    logic [CW-1:0]          mn_reg, mn_next, mx_reg, mx_next;

    logic [AW-1:0]          act;
    logic [N_WORKERS-1:0]   act_mask, done_sel, done_new;
    logic                   all_sel, all_new, can_emit, ahead, fin_op, fin_c;
    logic [CW-1:0]          loc_sel_q, glob_sel, mn_c, mx_c;
    logic [WIDX-1:0]        wi, wq;
    logic                   oload;
    rsp_t                   odata;

    always_comb
    begin
        if (active_workers == 4'd0)
        begin
            act = AW'(1);
        end
        else if (int'(active_workers) > N_WORKERS)
        begin
            act = AW'(N_WORKERS);
        end
        else
        begin
            act = AW'(active_workers);
        end
        for (int i = 0; i < N_WORKERS; i++)
        begin
            act_mask[i] = (i < int'(act));
        end
    end

    assign done_sel  = sel_reg ? add_done_reg : get_done_reg;
    assign all_sel   = &(done_sel | ~act_mask);
    assign glob_sel  = sel_reg ? add_glob_reg : get_glob_reg;
    assign loc_sel_q = sel_reg ? (add_rdv_reg ? add_rd_reg : '0)
                               : (get_rdv_reg ? get_rd_reg : '0);
    assign can_emit  = !ov_reg || rsp_ready;
    assign wi        = widx(w_reg);
    assign wq        = (state_reg == S_POP) ? widx(q_rd_reg.worker) : wi;
    // the finishing worker is kept apart from the worker of a drained request
    assign done_new  = done_sel | (N_WORKERS'(1) << widx(fw_reg));
    assign all_new   = &(done_new | ~act_mask);

    // scan step over the live workers
    always_comb
    begin
        mn_c = mn_reg;
        mx_c = mx_reg;
        if (scan_dv_reg && !done_sel[scan_ci_reg])
        begin
            if (loc_sel_q < mn_c)
            begin
                mn_c = loc_sel_q;
            end
            if (loc_sel_q > mx_c)
            begin
                mx_c = loc_sel_q;
            end
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        w_next        = w_reg;
        fw_next       = fw_reg;
        tag_next      = tag_reg;
        pay_next      = pay_reg;
        is_add_next   = is_add_reg;
        sel_next      = sel_reg;
        ctx_next      = ctx_reg;
        op_fin_next   = op_fin_reg;
        dkind_next    = dkind_reg;
        fin2_next     = fin2_reg;
        n_next        = n_reg;
        pend_vld_next = pend_vld_reg;
        pend_next     = pend_reg;
        scan_idx_next = scan_idx_reg;
        scan_ci_next  = scan_ci_reg;
        scan_dv_next  = scan_dv_reg;
        mn_next       = mn_reg;
        mx_next       = mx_reg;
        get_done_next = get_done_reg;
        add_done_next = add_done_reg;
        get_glob_next = get_glob_reg;
        add_glob_next = add_glob_reg;
        waited_next   = waited_reg;
        cmd_ready     = 1'b0;
        ra            = wi;
        loc_we        = 1'b0;
        loc_wdata     = loc_sel_q + 1'b1;
        q_push        = 1'b0;
        q_pop         = 1'b0;
        q_wdata       = '{tag: tag_reg, worker: w_reg, pay: pay_reg};
        oload         = 1'b0;
        odata         = pend_reg;
        fin_op        = 1'b0;
        fin_c         = 1'b0;
        ahead         = 1'b0;

        unique case (state_reg)
            S_FETCH:
            begin
                if (cmd_valid)
                begin
                    cmd_ready = 1'b1;
                    ra        = widx(cmd.worker);
                    w_next    = cmd.worker;
                    fw_next   = cmd.worker;
                    tag_next  = cmd.tag;
                    pay_next  = cmd.pay;
                    n_next    = '0;
                    fin2_next = 1'b0;
                    unique case (cmd.kind)
                        CMD_GET:
                        begin
                            is_add_next = 1'b0;
                            sel_next    = KIND_ADD;
                            state_next  = S_AHEAD;
                        end
                        CMD_ADD:
                        begin
                            is_add_next = 1'b1;
                            sel_next    = KIND_GET;
                            state_next  = S_AHEAD;
                        end
                        CMD_FIN:
                        begin
                            sel_next   = KIND_ADD;
                            ctx_next   = CX_FIN1;
                            state_next = S_FIN;
                        end
                        default:
                        begin
                            pend_vld_next = 1'b1;
                            pend_next     = '{status: 1'b0,
                                              out_kind: (cmd.kind == CMD_PASS_ADD),
                                              out_worker: cmd.worker, out_tag: cmd.tag,
                                              send_reply: cmd.pay, last: 1'b0};
                            n_next        = NCNT_W'(1);
                            state_next    = S_END;
                        end
                    endcase
                end
            end
            S_AHEAD:
            begin
                ahead = !all_sel && (done_sel[wi] || (loc_sel_q > glob_sel));
                if (!is_add_reg && (waited_reg[wq] != 4'd0))
                begin
                    ahead = 1'b1;
                end
                n_next = NCNT_W'(1);
                if (ahead)
                begin
                    if ((is_add_reg ? aq_cnt_reg : gq_cnt_reg) == QCW'(QUEUE_DEPTH))
                    begin
                        pend_vld_next = 1'b1;
                        pend_next     = '{status: 1'b1, out_kind: is_add_reg,
                                          out_worker: w_reg, out_tag: tag_reg,
                                          send_reply: 1'b0, last: 1'b0};
                    end
                    else
                    begin
                        q_push = 1'b1;
                        n_next = '0;
                        if (is_add_reg && (waited_reg[wq] != WAIT_MAX))
                        begin
                            waited_next[wq] = waited_reg[wq] + 1'b1;
                        end
                    end
                    state_next = S_END;
                end
                else
                begin
                    pend_vld_next = 1'b1;
                    pend_next     = '{status: 1'b0, out_kind: is_add_reg,
                                      out_worker: w_reg, out_tag: tag_reg,
                                      send_reply: pay_reg, last: 1'b0};
                    sel_next      = is_add_reg;
                    ctx_next      = CX_REL;
                    state_next    = S_UPD;
                end
            end
            S_UPD:
            begin
                loc_we = !done_sel[wi];
                if (all_sel)
                begin
                    fin_op = 1'b1;
                end
                else
                begin
                    scan_idx_next = '0;
                    scan_dv_next  = 1'b0;
                    mn_next       = '1;
                    mx_next       = '0;
                    op_fin_next   = 1'b0;
                    state_next    = S_SCAN;
                end
            end
            S_SCAN:
            begin
                mn_next = mn_c;
                mx_next = mx_c;
                if (scan_idx_reg < act)
                begin
                    ra            = scan_idx_reg[WIDX-1:0];
                    scan_ci_next  = scan_idx_reg[WIDX-1:0];
                    scan_dv_next  = 1'b1;
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
                else
                begin
                    scan_dv_next = 1'b0;
                end
                if (scan_dv_reg && (AW'(scan_ci_reg) == act - 1'b1))
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                fin_op = 1'b1;
                if (glob_sel < mn_reg)
                begin
                    if (op_fin_reg)
                    begin
                        if (sel_reg) add_glob_next = mn_reg;
                        else         get_glob_next = mn_reg;
                        fin_c = (mx_reg == mn_reg);
                    end
                    else
                    begin
                        if (sel_reg) add_glob_next = glob_sel + 1'b1;
                        else         get_glob_next = glob_sel + 1'b1;
                        fin_c = (mx_reg <= glob_sel + 1'b1);
                    end
                end
            end
            S_FIN:
            begin
                if (sel_reg) add_done_next = done_new;
                else         get_done_next = done_new;
                if (all_new)
                begin
                    fin_op = 1'b1;
                    fin_c  = !all_sel;
                end
                else
                begin
                    scan_idx_next = '0;
                    scan_dv_next  = 1'b0;
                    mn_next       = '1;
                    mx_next       = '0;
                    op_fin_next   = 1'b1;
                    state_next    = S_SCAN;
                end
            end
            S_DRAIN:
            begin
                if (((dkind_reg ? aq_cnt_reg : gq_cnt_reg) == '0) ||
                    (n_reg >= NCNT_W'(MAX_RESULTS)))
                begin
                    if (fin2_reg)
                    begin
                        fin2_next  = 1'b0;
                        sel_next   = KIND_GET;
                        ctx_next   = CX_FIN2;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        state_next = S_END;
                    end
                end
                else
                begin
                    q_pop      = 1'b1;
                    state_next = S_POP;
                end
            end
            S_POP:
            begin
                ra = widx(q_rd_reg.worker);
                if (!pend_vld_reg || can_emit)
                begin
                    oload         = pend_vld_reg;
                    pend_vld_next = 1'b1;
                    pend_next     = '{status: 1'b0, out_kind: dkind_reg,
                                      out_worker: q_rd_reg.worker, out_tag: q_rd_reg.tag,
                                      send_reply: q_rd_reg.pay, last: 1'b0};
                    n_next        = n_reg + 1'b1;
                    if (dkind_reg && (waited_reg[wq] != 4'd0))
                    begin
                        waited_next[wq] = waited_reg[wq] - 1'b1;
                    end
                    w_next     = q_rd_reg.worker;
                    sel_next   = dkind_reg;
                    ctx_next   = CX_DRAIN;
                    state_next = S_UPD;
                end
            end
            S_END:
            begin
                if (!pend_vld_reg)
                begin
                    state_next = S_FETCH;
                end
                else if (can_emit)
                begin
                    oload         = 1'b1;
                    odata.last    = 1'b1;
                    pend_vld_next = 1'b0;
                    state_next    = S_FETCH;
                end
            end
            default: state_next = S_FETCH;
        endcase

        // where a finished clock step leads
        if (fin_op)
        begin
            if (ctx_reg == CX_DRAIN)
            begin
                state_next = S_DRAIN;
            end
            else if (fin_c)
            begin
                dkind_next = ~sel_reg;
                fin2_next  = (ctx_reg == CX_FIN1);
                state_next = S_DRAIN;
            end
            else if (ctx_reg == CX_FIN1)
            begin
                sel_next   = KIND_GET;
                ctx_next   = CX_FIN2;
                state_next = S_FIN;
            end
            else
            begin
                state_next = S_END;
            end
        end
    end

    // output register
    always_comb
    begin
        ov_next  = ov_reg && !rsp_ready;
        out_next = out_reg;
        if (oload)
        begin
            ov_next  = 1'b1;
            out_next = odata;
        end
    end

    assign rsp_valid = ov_reg;
    assign rsp       = out_reg;

    // queue pointers
    always_comb
    begin
        gq_head_next = gq_head_reg;
        gq_tail_next = gq_tail_reg;
        gq_cnt_next  = gq_cnt_reg;
        aq_head_next = aq_head_reg;
        aq_tail_next = aq_tail_reg;
        aq_cnt_next  = aq_cnt_reg;
        if (q_push && is_add_reg)
        begin
            aq_tail_next = (aq_tail_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : aq_tail_reg + 1'b1;
            aq_cnt_next  = aq_cnt_reg + 1'b1;
        end
        if (q_push && !is_add_reg)
        begin
            gq_tail_next = (gq_tail_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : gq_tail_reg + 1'b1;
            gq_cnt_next  = gq_cnt_reg + 1'b1;
        end
        if (q_pop && dkind_reg)
        begin
            aq_head_next = (aq_head_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : aq_head_reg + 1'b1;
            aq_cnt_next  = aq_cnt_reg - 1'b1;
        end
        if (q_pop && !dkind_reg)
        begin
            gq_head_next = (gq_head_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : gq_head_reg + 1'b1;
            gq_cnt_next  = gq_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_push && is_add_reg)
        begin
            aq_mem[aq_tail_reg] <= q_wdata;
        end
        if (q_push && !is_add_reg)
        begin
            gq_mem[gq_tail_reg] <= q_wdata;
        end
        if (q_pop)
        begin
            q_rd_reg <= dkind_reg ? aq_mem[aq_head_reg] : gq_mem[gq_head_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (loc_we && sel_reg)
        begin
            add_loc_mem[wi] <= loc_wdata;
        end
        if (loc_we && !sel_reg)
        begin
            get_loc_mem[wi] <= loc_wdata;
        end
        get_rd_reg <= get_loc_mem[ra];
        add_rd_reg <= add_loc_mem[ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            get_vld_reg <= '0;
            add_vld_reg <= '0;
            get_rdv_reg <= 1'b0;
            add_rdv_reg <= 1'b0;
        end
        else
        begin
            if (loc_we && sel_reg)
            begin
                add_vld_reg[wi] <= 1'b1;
            end
            if (loc_we && !sel_reg)
            begin
                get_vld_reg[wi] <= 1'b1;
            end
            get_rdv_reg <= get_vld_reg[ra];
            add_rdv_reg <= add_vld_reg[ra];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_FETCH;
            ctx_reg      <= CX_REL;
            op_fin_reg   <= 1'b0;
            dkind_reg    <= KIND_GET;
            fin2_reg     <= 1'b0;
            sel_reg      <= KIND_GET;
            is_add_reg   <= 1'b0;
            n_reg        <= '0;
            pend_vld_reg <= 1'b0;
            ov_reg       <= 1'b0;
            scan_idx_reg <= '0;
            scan_dv_reg  <= 1'b0;
            get_done_reg <= '0;
            add_done_reg <= '0;
            get_glob_reg <= '0;
            add_glob_reg <= '0;
            gq_head_reg  <= '0;
            gq_tail_reg  <= '0;
            gq_cnt_reg   <= '0;
            aq_head_reg  <= '0;
            aq_tail_reg  <= '0;
            aq_cnt_reg   <= '0;
            for (int i = 0; i < N_WORKERS; i++)
            begin
                waited_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            ctx_reg      <= ctx_next;
            op_fin_reg   <= op_fin_next;
            dkind_reg    <= dkind_next;
            fin2_reg     <= fin2_next;
            sel_reg      <= sel_next;
            is_add_reg   <= is_add_next;
            n_reg        <= n_next;
            pend_vld_reg <= pend_vld_next;
            ov_reg       <= ov_next;
            scan_idx_reg <= scan_idx_next;
            scan_dv_reg  <= scan_dv_next;
            get_done_reg <= get_done_next;
            add_done_reg <= add_done_next;
            get_glob_reg <= get_glob_next;
            add_glob_reg <= add_glob_next;
            gq_head_reg  <= gq_head_next;
            gq_tail_reg  <= gq_tail_next;
            gq_cnt_reg   <= gq_cnt_next;
            aq_head_reg  <= aq_head_next;
            aq_tail_reg  <= aq_tail_next;
            aq_cnt_reg   <= aq_cnt_next;
            waited_reg   <= waited_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg       <= w_next;
        fw_reg      <= fw_next;
        tag_reg     <= tag_next;
        pay_reg     <= pay_next;
        pend_reg    <= pend_next;
        out_reg     <= out_next;
        scan_ci_reg <= scan_ci_next;
        mn_reg      <= mn_next;
        mx_reg      <= mx_next;
    end

endmodule

### design/sync_barrier_request_scheduler.sv
// Lockstep request scheduler: get, add and finish requests from up to
// N_WORKERS workers are released, deferred or rejected so that get and add
// vector clocks stay in step. Requests pass a 4-entry command queue, then a
// sequencer handles one at a time. With sync on, a released request and each
// request drained from a deferral queue may run a scan for the live minimum
// and maximum, and a finish notice up to two such scans; the scan reads one
// worker a cycle through the single read address that the get and add clock
// count memories share. Counts reset through per-worker valid bits, so there
// is no clearing pass after reset.
// depends on sbrs_pkg, sbrs_front, sbrs_back
module sync_barrier_request_scheduler #(
    parameter int N_WORKERS = 8,
    parameter int QUEUE_DEPTH = 8,
    parameter int CLOCK_WIDTH = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  logic           cfg_index,
    input  logic [3:0]     cfg_data,
    input  logic           req_valid,
    output logic           req_ready,
    input  sbrs_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output sbrs_pkg::rsp_t rsp
);
    import sbrs_pkg::*;

    logic       sync_reg;
    logic [3:0] act_reg;
    logic       cmd_valid, cmd_ready;
    cmd_t       cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_reg <= 1'b0;
            act_reg  <= 4'd8;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SYNC: sync_reg <= cfg_data[0];
                CFG_ACT:  act_reg  <= cfg_data;
                default:  ;
            endcase
        end
    end

    sbrs_front #(
        .N_WORKERS(N_WORKERS)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .sync_enable(sync_reg),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req(req),
        .cmd_valid(cmd_valid),
        .cmd_ready(cmd_ready),
        .cmd(cmd)
    );

    sbrs_back #(
        .N_WORKERS(N_WORKERS),
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .CLOCK_WIDTH(CLOCK_WIDTH)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .active_workers(act_reg),
        .cmd_valid(cmd_valid),
        .cmd_ready(cmd_ready),
        .cmd(cmd),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp(rsp)
    );

endmodule

### design/sbrs_checker.sv
// port-level checks of the scheduler's result channel
// depends on sbrs_pkg; bound to sync_barrier_request_scheduler
module sbrs_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           rsp_valid,
    input logic           rsp_ready,
    input sbrs_pkg::rsp_t rsp
);
    import sbrs_pkg::*;

    // a rejection is always marked as the last result of its transaction
    a_reject_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status |-> rsp.last)
        else $error("rejected transaction not marked last");

    a_reject_no_reply: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status |-> !rsp.send_reply)
        else $error("rejected transaction asks for a reply");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("stalled result changed");

endmodule

bind sync_barrier_request_scheduler sbrs_checker u_sbrs_checker (.*);

### dv/sync_barrier_request_scheduler_tb.sv
// testbench for the lockstep request scheduler: directed and random request streams
// checked against an in-bench model of both vector clocks and deferral queues
// depends on sbrs_pkg and sync_barrier_request_scheduler
module sync_barrier_request_scheduler_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sbrs_pkg::*;

    localparam int NW         = 8;
    localparam int QDEPTH     = 8;
    localparam int SETTLE     = 400;
    localparam int LIMIT      = 1000000;
    localparam int HOLD_LEN   = 300;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic       cfg_index;
    logic [3:0] cfg_data;
    logic       req_valid;
    logic       req_ready;
    req_t       req;
    logic       rsp_valid;
    logic       rsp_ready;
    rsp_t       rsp;

    sync_barrier_request_scheduler dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .req_valid(req_valid), .req_ready(req_ready), .req(req),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // scheduler model state, index 0 is the get clock, 1 the add clock
    bit          sync_on;
    logic [3:0]  act_reg;
    logic [31:0] loc_cnt [2][NW];
    bit          wdone   [2][NW];
    logic [31:0] glob_cnt [2];
    logic [3:0]  waited [NW];
    entry_t      get_defer_q [$];
    entry_t      add_defer_q [$];
    rsp_t        step_out [$];
    rsp_t        expected_rsp_q [$];

    int send_idle;
    int rcv_idle;
    int hold_seq;
    int seen_seq;
    int hold_left;
    int cycles;
    int mismatches;

    function automatic int live_workers();
        int a;
        a = act_reg;
        if (a == 0) a = 1;
        if (a > NW) a = NW;
        return a;
    endfunction

    function automatic bit clock_all_done(int k);
        for (int i = 0; i < live_workers(); i++)
            if (!wdone[k][i]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic bit clock_ahead(int k, int w);
        if (clock_all_done(k)) return 1'b0;
        if (wdone[k][w]) return 1'b1;
        return loc_cnt[k][w] > glob_cnt[k];
    endfunction

    function automatic logic [31:0] clock_min(int k);
        logic [31:0] mn;
        mn = 32'hFFFF_FFFF;
        for (int i = 0; i < live_workers(); i++)
            if (!wdone[k][i] && loc_cnt[k][i] < mn) mn = loc_cnt[k][i];
        return mn;
    endfunction

    function automatic bit round_done(int k);
        logic [31:0] mx;
        mx = glob_cnt[k];
        for (int i = 0; i < live_workers(); i++)
            if (!wdone[k][i] && loc_cnt[k][i] > mx) mx = loc_cnt[k][i];
        return glob_cnt[k] == mx;
    endfunction

    function automatic bit clock_tick(int k, int w);
        if (!wdone[k][w]) loc_cnt[k][w] = loc_cnt[k][w] + 32'd1;
        if (clock_all_done(k)) return 1'b0;
        if (glob_cnt[k] < clock_min(k))
        begin
            glob_cnt[k] = glob_cnt[k] + 32'd1;
            return round_done(k);
        end
        return 1'b0;
    endfunction

    function automatic bit clock_retire(int k, int w);
        bit was;
        logic [31:0] mn;
        was = clock_all_done(k);
        wdone[k][w] = 1'b1;
        if (clock_all_done(k)) return !was;
        mn = clock_min(k);
        if (glob_cnt[k] < mn)
        begin
            glob_cnt[k] = mn;
            return round_done(k);
        end
        return 1'b0;
    endfunction

    function automatic void put_result(logic st, logic kind, logic [2:0] w,
                                       logic [15:0] tag, logic reply);
        rsp_t r;
        if (step_out.size() >= MAX_RESULTS) return;
        r.status = st;
        r.out_kind = kind;
        r.out_worker = w;
        r.out_tag = tag;
        r.send_reply = reply;
        r.last = 1'b0;
        step_out = {step_out, r};
    endfunction

    function automatic void release_deferred(logic kind);
        entry_t e;
        while (((kind == KIND_GET) ? get_defer_q.size() : add_defer_q.size()) > 0
               && step_out.size() < MAX_RESULTS)
        begin
            e = (kind == KIND_GET) ? get_defer_q.pop_front() : add_defer_q.pop_front();
            put_result(1'b0, kind, e.worker, e.tag, e.pay);
            void'(clock_tick(kind, e.worker));
            if (kind == KIND_ADD && waited[e.worker] > 0)
                waited[e.worker] = waited[e.worker] - 4'd1;
        end
    endfunction

    function automatic void schedule_request(req_t r);
        int w;
        entry_t e;
        w = r.worker_index;
        e.tag = r.request_tag;
        e.worker = r.worker_index;
        e.pay = r.has_payload;
        step_out.delete();
        if (r.mode == MODE_NONE) return;
        if (!sync_on)
        begin
            if (r.mode != MODE_FIN)
                put_result(1'b0, r.mode[0], e.worker, e.tag, e.pay);
        end
        else if (r.mode == MODE_ADD)
        begin
            if (clock_ahead(KIND_GET, w))
            begin
                if (add_defer_q.size() >= QDEPTH)
                    put_result(1'b1, KIND_ADD, e.worker, e.tag, 1'b0);
                else
                begin
                    add_defer_q = {add_defer_q, e};
                    if (waited[w] < WAIT_MAX) waited[w] = waited[w] + 4'd1;
                end
            end
            else
            begin
                put_result(1'b0, KIND_ADD, e.worker, e.tag, e.pay);
                if (clock_tick(KIND_ADD, w)) release_deferred(KIND_GET);
            end
        end
        else if (r.mode == MODE_GET)
        begin
            if (clock_ahead(KIND_ADD, w) || waited[w] > 0)
            begin
                if (get_defer_q.size() >= QDEPTH)
                    put_result(1'b1, KIND_GET, e.worker, e.tag, 1'b0);
                else
                    get_defer_q = {get_defer_q, e};
            end
            else
            begin
                put_result(1'b0, KIND_GET, e.worker, e.tag, e.pay);
                if (clock_tick(KIND_GET, w)) release_deferred(KIND_ADD);
            end
        end
        else
        begin
            if (clock_retire(KIND_ADD, w)) release_deferred(KIND_GET);
            if (clock_retire(KIND_GET, w)) release_deferred(KIND_ADD);
        end
        if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
        foreach (step_out[i]) expected_rsp_q = {expected_rsp_q, step_out[i]};
    endfunction

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_seq != seen_seq)
        begin
            seen_seq = hold_seq;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_ready <= 1'b0;
        end
        else
            rsp_ready <= ($urandom_range(99) >= rcv_idle);
    end

    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_rsp_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transaction: status=%0d kind=%0d",
                             rsp.status, rsp.out_kind,
                             " worker=%0d tag=%h", rsp.out_worker, rsp.out_tag);
            end
            else
            begin
                want = expected_rsp_q.pop_front();
                if (rsp.status !== want.status || rsp.out_kind !== want.out_kind ||
                    rsp.out_worker !== want.out_worker || rsp.out_tag !== want.out_tag ||
                    rsp.send_reply !== want.send_reply || rsp.last !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp st=%0d k=%0d w=%0d tag=%h rep=%0d last=%0d",
                                 want.status, want.out_kind, want.out_worker, want.out_tag,
                                 want.send_reply, want.last,
                                 " / got st=%0d k=%0d w=%0d tag=%h rep=%0d last=%0d",
                                 rsp.status, rsp.out_kind, rsp.out_worker, rsp.out_tag,
                                 rsp.send_reply, rsp.last);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_request(logic [1:0] mode, int w, logic [15:0] tag, logic pay);
        req_t r;
        r.mode = mode;
        r.worker_index = w[2:0];
        r.request_tag = tag;
        r.has_payload = pay;
        if ($urandom_range(99) < send_idle)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle) @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        schedule_request(r);
    endtask

    task automatic send_random(logic [1:0] mode, int w);
        send_request(mode, w, 16'($urandom), 1'($urandom));
    endtask

    // idle the sender and let every outstanding transaction come back
    task automatic wait_drained();
        req_valid <= 1'b0;
        while (expected_rsp_q.size() > 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [3:0] val);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_SYNC) sync_on = val[0];
        else act_reg = val;
    endtask

    task automatic test_sync_off();
        write_reg(CFG_SYNC, 4'd0);
        send_request(MODE_GET, 0, 16'h0000, 1'b0);
        send_request(MODE_ADD, 7, 16'hFFFF, 1'b1);
        send_request(MODE_FIN, 3, 16'h1234, 1'b1);
        send_request(MODE_NONE, 5, 16'hA5A5, 1'b0);
        send_request(MODE_ADD, 0, 16'h5A5A, 1'b0);
        send_request(MODE_GET, 7, 16'hFFFF, 1'b1);
    endtask

    // deferral queues fill up and then drain when the slow worker catches up
    task automatic test_defer_and_reject();
        write_reg(CFG_ACT, 4'd2);
        write_reg(CFG_SYNC, 4'd1);
        send_random(MODE_GET, 0);
        for (int i = 0; i < QDEPTH + 1; i++) send_random(MODE_ADD, 0);
        send_random(MODE_GET, 1);
        send_random(MODE_ADD, 1);
        for (int i = 0; i < QDEPTH + 1; i++) send_random(MODE_GET, 0);
        send_random(MODE_NONE, 1);
        for (int i = 0; i < QDEPTH - 1; i++) send_random(MODE_ADD, 1);
    endtask

    task automatic run_rounds(int n_items, bit allow_fin, int pause_at, int hold_at);
        int pend [NW];
        int sent;
        int w;
        bit any;
        logic [1:0] m;
        sent = 0;
        foreach (pend[i]) pend[i] = 0;
        while (sent < n_items)
        begin
            if (sent == pause_at) wait_drained();
            if (sent == hold_at) hold_seq <= hold_seq + 1;
            any = 1'b0;
            foreach (pend[i]) if (pend[i] > 0) any = 1'b1;
            if (!any)
                for (int i = 0; i < live_workers(); i++) pend[i] = 2;
            if ($urandom_range(99) < 10)
            begin
                m = 2'($urandom_range(3));
                if (m == MODE_FIN && !allow_fin) m = MODE_NONE;
                send_random(m, $urandom_range(NW - 1));
            end
            else if (allow_fin && $urandom_range(99) < 3)
                send_random(MODE_FIN, $urandom_range(live_workers() - 1));
            else
            begin
                do w = $urandom_range(NW - 1); while (pend[w] == 0);
                send_random((pend[w] == 2) ? MODE_GET : MODE_ADD, w);
                pend[w]--;
            end
            sent++;
        end
    endtask

    task automatic test_random_phases();
        send_idle = 33;
        rcv_idle = 82;
        write_reg(CFG_ACT, 4'd0);
        run_rounds(40, 1'b0, -1, 20);
        write_reg(CFG_ACT, 4'd15);
        run_rounds(70, 1'b0, 35, -1);
        send_idle = 82;
        rcv_idle = 33;
        write_reg(CFG_ACT, 4'd8);
        run_rounds(60, 1'b0, -1, 30);
        write_reg(CFG_SYNC, 4'd0);
        run_rounds(30, 1'b1, -1, -1);
        write_reg(CFG_SYNC, 4'd1);
        write_reg(CFG_ACT, 4'($urandom_range(1, 8)));
        send_idle = 0;
        rcv_idle = 0;
        run_rounds(70, 1'b0, -1, 10);
    endtask

    task automatic test_finish();
        write_reg(CFG_ACT, 4'd4);
        run_rounds(60, 1'b1, -1, -1);
        for (int i = 0; i < 4; i++) send_random(MODE_FIN, i);
        run_rounds(20, 1'b0, -1, -1);
    endtask

    initial
    begin
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_SYNC;
        cfg_data <= 4'd0;
        req_valid <= 1'b0;
        req <= '0;
        send_idle = 33;
        rcv_idle = 82;
        hold_seq = 0;
        seen_seq = 0;
        hold_left = 0;
        cycles = 0;
        mismatches = 0;
        sync_on = 1'b0;
        act_reg = 4'd8;
        for (int k = 0; k < 2; k++)
        begin
            glob_cnt[k] = 32'd0;
            for (int i = 0; i < NW; i++)
            begin
                loc_cnt[k][i] = 32'd0;
                wdone[k][i] = 1'b0;
            end
        end
        foreach (waited[i]) waited[i] = 4'd0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_sync_off();
        test_defer_and_reject();
        test_random_phases();
        test_finish();
        wait_drained();
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
